// File: sv/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int HEAP_BYTES    = 65536;

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int START_W = $clog2(HEAP_BYTES);
  localparam int LEN_W   = $clog2(HEAP_BYTES + 1);
  localparam int SIZE_W  = 17;
  localparam int ADDR_W  = 16;
  localparam int CMP_W   = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
  localparam int AW_W    = (START_W > ADDR_W) ? START_W : ADDR_W;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_HIT  = 2'd1;
  localparam logic [1:0] SEL_NEW  = 2'd2;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               occ;
  } entry_t;

  typedef struct packed {
    logic       wr_init;
    logic       take_req;
    logic       scan_run;
    logic       wr_hit;
    logic       shift_init;
    logic       shift_run;
    logic       wr_new;
    logic       set_res;
    logic [1:0] res_code;
    logic [1:0] res_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic req_alloc;
    logic zero_alloc;
    logic hit;
    logic last;
    logic exact;
    logic full;
    logic shift_done;
  } stat_t;

  function automatic logic [ADDR_W-1:0] addr_lo(input logic [START_W-1:0] s);
    logic [AW_W-1:0] w;
    w = AW_W'(s);
    return w[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/first_fit_block_allocator.sv
// First-fit allocator over an ordered region table of TABLE_ENTRIES entries
// held in a single-port-write, single-read memory. One request at a time:
// the table is read one entry per cycle from the front until the first fit
// (allocate) or the matching start address (free), or through the last entry
// when nothing matches; a zero-size allocate is answered without a scan. An
// allocate that splits a region also moves every later entry up by one, one
// entry per cycle. The result sits in an output register; while that
// register is held by a stalled beat the block waits in its final state, and
// the next request is taken from the cycle after the result is loaded. After
// reset the block writes the initial whole-heap region before it accepts a
// request. Neighboring free regions are never merged.

`default_nettype none

module first_fit_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [ffba_pkg::SIZE_W-1:0] req_size,
  input  logic [ffba_pkg::ADDR_W-1:0] free_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [ffba_pkg::ADDR_W-1:0] alloc_addr
);
  import ffba_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ffba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .req_size   (req_size),
    .free_addr  (free_addr),
    .status     (status),
    .alloc_addr (alloc_addr),
    .cmd        (cmd),
    .st         (st)
  );

  a_no_insert_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |-> !st.full)
    else $error("insert into a full region table");

  a_one_write_source: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.wr_init, cmd.wr_hit, cmd.wr_new}))
    else $error("two table writes in one cycle");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output beat overwritten while stalled");

  a_take_only_when_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.take_req |-> (in_valid && !in_stall))
    else $error("request latched outside an input beat");

endmodule

`default_nettype wire

// File: sv/ffba_dp.sv
`default_nettype none

module ffba_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          func,
  input  logic [ffba_pkg::SIZE_W-1:0]   req_size,
  input  logic [ffba_pkg::ADDR_W-1:0]   free_addr,
  output logic [1:0]                    status,
  output logic [ffba_pkg::ADDR_W-1:0]   alloc_addr,
  input  ffba_pkg::cmd_t                cmd,
  output ffba_pkg::stat_t               st
);
  import ffba_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  logic              req_func;
  logic [SIZE_W-1:0] req_sz;
  logic [ADDR_W-1:0] req_addr;

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  rd_idx;
  logic              ev_vld;
  logic [CNT_W-1:0]  ev_idx;
  entry_t            rd_q;

  logic [IDX_W-1:0]  hit_idx;
  entry_t            hit_ent;

  logic [CNT_W-1:0]  sh_src;
  logic              wr_pend;
  logic [IDX_W-1:0]  wr_idx;

  logic [1:0]        res_code;
  logic [ADDR_W-1:0] res_addr;

  logic              match;
  logic              issue_scan;
  logic              issue_shift;
  logic              exact;
  logic [LEN_W-1:0]  rem_len;
  logic [START_W-1:0] new_start;
  logic [CNT_W-1:0]  new_idx_w;
  logic [CNT_W-1:0]  sh_dst_w;
  logic [CNT_W-1:0]  last_idx;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            hit_wr;
  entry_t            new_ent;
  entry_t            init_ent;
  logic [ADDR_W-1:0] sel_addr;

  always_comb begin
    if (req_func) begin
      match = (AW_W'(rd_q.start) == AW_W'(req_addr));
    end else begin
      match = !rd_q.occ && (CMP_W'(rd_q.len) >= CMP_W'(req_sz));
    end
  end

  assign issue_scan  = rd_idx < cnt;
  assign issue_shift = sh_src > CNT_W'(hit_idx);
  assign exact       = CMP_W'(hit_ent.len) == CMP_W'(req_sz);
  // only used on a split, where the request is below the region length
  assign rem_len     = hit_ent.len - LEN_W'(req_sz);
  assign new_start   = hit_ent.start + START_W'(rem_len);
  assign new_idx_w   = CNT_W'(hit_idx) + CNT_W'(1);
  assign sh_dst_w    = sh_src + CNT_W'(1);
  assign last_idx    = cnt - CNT_W'(1);
  assign rd_addr     = cmd.scan_run ? rd_idx[IDX_W-1:0] : sh_src[IDX_W-1:0];

  always_comb begin
    if (req_func) begin
      hit_wr = '{start: hit_ent.start, len: hit_ent.len, occ: 1'b0};
    end else if (exact) begin
      hit_wr = '{start: hit_ent.start, len: hit_ent.len, occ: 1'b1};
    end else begin
      hit_wr = '{start: hit_ent.start, len: rem_len, occ: 1'b0};
    end
  end

  assign new_ent  = '{start: new_start, len: LEN_W'(req_sz), occ: 1'b1};
  assign init_ent = '{start: '0, len: LEN_W'(HEAP_BYTES), occ: 1'b0};

  always_comb begin
    case (cmd.res_sel)
      SEL_HIT: sel_addr = addr_lo(hit_ent.start);
      SEL_NEW: sel_addr = addr_lo(new_start);
      default: sel_addr = '0;
    endcase
  end

  assign st.req_alloc  = !req_func;
  assign st.zero_alloc = !req_func && (req_sz == '0);
  assign st.hit        = ev_vld && match;
  assign st.last       = ev_vld && (ev_idx == last_idx);
  assign st.exact      = exact;
  assign st.full       = cnt == CNT_W'(TABLE_ENTRIES);
  assign st.shift_done = !issue_shift && !wr_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= CNT_W'(1);
      rd_idx  <= '0;
      ev_vld  <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      if (cmd.take_req) begin
        rd_idx <= '0;
        ev_vld <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_idx <= rd_idx + CNT_W'(issue_scan);
        ev_vld <= issue_scan;
      end
      wr_pend <= cmd.shift_run && issue_shift;
      if (cmd.wr_new) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (cmd.take_req) begin
      req_func <= func;
      req_sz   <= req_size;
      req_addr <= free_addr;
    end
    if (cmd.scan_run) begin
      ev_idx <= rd_idx;
      if (st.hit) begin
        hit_idx <= ev_idx[IDX_W-1:0];
        hit_ent <= rd_q;
      end
    end
    if (cmd.shift_init) begin
      sh_src <= last_idx;
    end else if (cmd.shift_run && issue_shift) begin
      sh_src <= sh_src - CNT_W'(1);
      wr_idx <= sh_dst_w[IDX_W-1:0];
    end
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
      res_addr <= sel_addr;
    end
    if (cmd.load_out) begin
      status     <= res_code;
      alloc_addr <= res_addr;
    end
  end

  // single write port: entry 0 after reset, hit entry, new entry, or a moved entry
  always_ff @(posedge clk) begin
    if (cmd.wr_init) begin
      mem[0] <= init_ent;
    end else if (cmd.wr_hit) begin
      mem[hit_idx] <= hit_wr;
    end else if (cmd.wr_new) begin
      mem[new_idx_w[IDX_W-1:0]] <= new_ent;
    end else if (wr_pend) begin
      mem[wr_idx] <= rd_q;
    end
  end

endmodule

`default_nettype wire

// File: sv/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ffba_pkg::stat_t st,
  output ffba_pkg::cmd_t  cmd
);
  import ffba_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_PLACE  = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.wr_init = 1'b1;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_req = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.zero_alloc) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOFIT;
          cmd.res_sel  = SEL_ZERO;
          state_next   = S_FIN;
        end else if (st.hit) begin
          state_next = S_DECIDE;
        end else if (st.last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = st.req_alloc ? ST_NOFIT : ST_NOTFOUND;
          cmd.res_sel  = SEL_ZERO;
          state_next   = S_FIN;
        end
      end
      S_DECIDE: begin
        if (!st.req_alloc || st.exact) begin
          cmd.wr_hit   = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OK;
          cmd.res_sel  = st.req_alloc ? SEL_HIT : SEL_ZERO;
          state_next   = S_FIN;
        end else if (st.full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FULL;
          cmd.res_sel  = SEL_ZERO;
          state_next   = S_FIN;
        end else begin
          // shrink the free part now, then open a slot after it
          cmd.wr_hit     = 1'b1;
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_run = 1'b1;
        if (st.shift_done) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_new   = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_OK;
        cmd.res_sel  = SEL_NEW;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/ffba_tb_pkg.sv
`default_nettype none

package ffba_tb_pkg;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

endpackage

`default_nettype wire

// File: tb/ffba_checker.sv
`default_nettype none

module ffba_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        func,
  input  logic [ffba_pkg::SIZE_W-1:0] req_size,
  input  logic [ffba_pkg::ADDR_W-1:0] free_addr,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  status,
  input  logic [ffba_pkg::ADDR_W-1:0] alloc_addr,
  output int                          fail_count,
  output int                          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;
  import ffba_tb_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } outcome_t;

  outcome_t expected_q[$];

  // shadow of the region table
  logic [START_W-1:0] rg_start [TABLE_ENTRIES];
  logic [LEN_W-1:0]   rg_len   [TABLE_ENTRIES];
  logic               rg_occ   [TABLE_ENTRIES];
  int                 rg_count;

  function automatic void clear_regions();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      rg_start[i] = '0;
      rg_len[i]   = '0;
      rg_occ[i]   = 1'b0;
    end
    rg_len[0] = LEN_W'(HEAP_BYTES);
    rg_count  = 1;
  endfunction

  function automatic outcome_t allocate_region(input logic [SIZE_W-1:0] size);
    int       i;
    int       hit;
    outcome_t res;
    res.status = ST_NOFIT;
    res.addr   = '0;
    hit        = -1;
    if (size == '0) return res;
    for (i = 0; i < rg_count && hit < 0; i++) begin
      if (!rg_occ[i] && CMP_W'(rg_len[i]) >= CMP_W'(size)) hit = i;
    end
    if (hit < 0) return res;
    if (CMP_W'(rg_len[hit]) == CMP_W'(size)) begin
      rg_occ[hit] = 1'b1;
      res.status  = ST_OK;
      res.addr    = ADDR_W'(rg_start[hit]);
      return res;
    end
    if (rg_count >= TABLE_ENTRIES) begin
      res.status = ST_FULL;
      return res;
    end
    // carve the request off the tail, open a slot right after the hit
    rg_len[hit] = rg_len[hit] - LEN_W'(size);
    for (i = rg_count; i > hit + 1; i--) begin
      rg_start[i] = rg_start[i-1];
      rg_len[i]   = rg_len[i-1];
      rg_occ[i]   = rg_occ[i-1];
    end
    rg_start[hit+1] = rg_start[hit] + START_W'(rg_len[hit]);
    rg_len[hit+1]   = LEN_W'(size);
    rg_occ[hit+1]   = 1'b1;
    rg_count++;
    res.status = ST_OK;
    res.addr   = ADDR_W'(rg_start[hit+1]);
    return res;
  endfunction

  function automatic outcome_t release_region(input logic [ADDR_W-1:0] addr);
    outcome_t res;
    res.status = ST_NOTFOUND;
    res.addr   = '0;
    for (int i = 0; i < rg_count; i++) begin
      if (res.status == ST_NOTFOUND && rg_start[i] == START_W'(addr)) begin
        rg_occ[i]  = 1'b0;
        res.status = ST_OK;
      end
    end
    return res;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    clear_regions();
  end

  always @(posedge clk) begin
    outcome_t exp_res;
    if (rst) begin
      clear_regions();
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (op_e'(func) == OP_FREE) expected_q.push_back(release_region(free_addr));
        else expected_q.push_back(allocate_region(req_size));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: status %0d, alloc_addr 'h%0h",
                 status, alloc_addr);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_q.pop_front();
          if (status !== exp_res.status || alloc_addr !== exp_res.addr) begin
            if (status !== exp_res.status)
              $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
            if (alloc_addr !== exp_res.addr)
              $error("alloc_addr mismatch: expected 'h%0h, actual 'h%0h",
                     exp_res.addr, alloc_addr);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= expected_q.size();
  end

endmodule

`default_nettype wire

// File: tb/first_fit_block_allocator_tb.sv
`default_nettype none

module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;
  import ffba_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * TABLE_ENTRIES + 24;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } block_t;

  typedef struct {
    op_e               op;
    logic [SIZE_W-1:0] size;
  } sent_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = OP_ALLOC;
  logic [SIZE_W-1:0] req_size = '0;
  logic [ADDR_W-1:0] free_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [ADDR_W-1:0] alloc_addr;

  int fail_count;
  int pending_count;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;

  // blocks handed out and blocks released, used to shape well-formed traffic
  block_t live_q[$];
  block_t freed_q[$];
  sent_t  sent_q[$];

  first_fit_block_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .req_size   (req_size),
    .free_addr  (free_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .alloc_addr (alloc_addr)
  );

  ffba_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .req_size      (req_size),
    .free_addr     (free_addr),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .alloc_addr    (alloc_addr),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("first_fit_block_allocator_tb: FAIL");
      $finish;
    end
  end

  // pair result beats with requests to learn which addresses are handed out
  always @(posedge clk) begin
    sent_t  s;
    block_t b;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        s.op   = op_e'(func);
        s.size = req_size;
        sent_q.push_back(s);
      end
      if (out_valid && !out_stall && sent_q.size() > 0) begin
        s = sent_q.pop_front();
        if (s.op == OP_ALLOC && status == ST_OK) begin
          b.addr = alloc_addr;
          b.size = s.size;
          live_q.push_back(b);
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input op_e op, input logic [SIZE_W-1:0] size,
                           input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= op;
    req_size  <= size;
    free_addr <= addr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic alloc_beat(input logic [SIZE_W-1:0] size);
    send_beat(OP_ALLOC, size, ADDR_W'($urandom));
  endtask

  task automatic free_beat(input logic [ADDR_W-1:0] addr);
    send_beat(OP_FREE, SIZE_W'($urandom), addr);
  endtask

  task automatic run_random(input int count, input int idle, input int stall);
    int                r;
    int                q;
    int                j;
    block_t            b;
    logic [SIZE_W-1:0] size;
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        q = $urandom_range(0, 9);
        if (q < 7 && live_q.size() > 0) begin
          j = $urandom_range(0, live_q.size() - 1);
          b = live_q[j];
          live_q.delete(j);
          freed_q.push_back(b);
          free_beat(b.addr);
        end else if (q < 8 && freed_q.size() > 0) begin
          // release twice
          free_beat(freed_q[$urandom_range(0, freed_q.size() - 1)].addr);
        end else begin
          free_beat(ADDR_W'($urandom));
        end
      end else begin
        if (r < 75 && freed_q.size() > 0) begin
          // same size again, usually lands exactly on the released region
          j = $urandom_range(0, freed_q.size() - 1);
          size = freed_q[j].size;
          freed_q.delete(j);
        end else if (r < 88) begin
          size = SIZE_W'($urandom_range(1, 1024));
        end else if (r < 93) begin
          size = SIZE_W'($urandom_range(1, 131071));
        end else if (r < 97) begin
          size = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(65537, 131071));
        end else begin
          size = SIZE_W'($urandom_range(1, HEAP_BYTES));
        end
        alloc_beat(size);
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: zero size, oversize, unknown address, exact fit, double free, splits
    alloc_beat('0);
    alloc_beat(SIZE_W'(131071));
    alloc_beat(SIZE_W'(HEAP_BYTES + 1));
    free_beat(ADDR_W'(16'h1234));
    alloc_beat(SIZE_W'(HEAP_BYTES));
    alloc_beat(SIZE_W'(1));
    free_beat('0);
    free_beat('0);
    alloc_beat(SIZE_W'(1));
    alloc_beat(SIZE_W'(HEAP_BYTES - 1));
    free_beat(ADDR_W'(16'hFFFF));
    free_beat(ADDR_W'(16'hFFFF));
    alloc_beat(SIZE_W'(1));
    free_beat('0);
    alloc_beat(SIZE_W'(32768));
    free_beat(ADDR_W'(16'h5555));
    free_beat(ADDR_W'(16'hAAAA));
    alloc_beat(SIZE_W'(40000));

    // hold off until every result is back
    wait_idle();

    run_random(470, 0, 0);
    run_random(470, 72, 0);
    run_random(470, 0, 72);
    run_random(470, 29, 29);

    wait_idle();
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("first_fit_block_allocator_tb: PASS");
    end else begin
      $display("first_fit_block_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
sv/ffba_pkg.sv
sv/ffba_dp.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator.sv
tb/ffba_tb_pkg.sv
tb/ffba_checker.sv
tb/first_fit_block_allocator_tb.sv
